### sv/cld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Content-length deframer package
// Shared types, character codes and the wanted header name.
// ----------------------------------------------------------------------------
package cld_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;
  localparam int NAME_LEN = 14;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [2:0] {
    PH_NAME   = 3'd0,
    PH_SKIP   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_IGNORE = 3'd3,
    PH_VTAIL  = 3'd4,
    PH_BODY   = 3'd5
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       first;
    logic       last;
  } cld_result_t;

  function automatic logic [7:0] wanted_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h6C; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_HT) || (c == CH_VT) || (c == CH_FF) ||
           (c == CH_CR);
  endfunction

endpackage

### sv/cld_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Content-length deframer parser
// Header state and body counter, advanced by one byte per step.
// ----------------------------------------------------------------------------
module cld_parser #(
  parameter int LENGTH_BITS = cld_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          byte_in,
  output cld_pkg::cld_result_t result
);
  import cld_pkg::*;

  localparam int WIDE_BITS = LENGTH_BITS + 4;

  phase_t                 phase, phase_next;
  logic [3:0]             name_position, name_position_next;
  logic                   name_mismatch, name_mismatch_next;
  logic                   line_has_content, line_has_content_next;
  logic [LENGTH_BITS-1:0] value_accumulator, value_accumulator_next;
  logic                   value_bad, value_bad_next;
  logic                   digit_seen, digit_seen_next;
  logic [LENGTH_BITS-1:0] message_length, message_length_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;

  logic                   clear_line;
  logic                   end_headers;
  logic                   is_digit;
  logic [3:0]             digit;
  logic [7:0]             lowered;
  logic [WIDE_BITS-1:0]   acc_wide;
  logic [WIDE_BITS-1:0]   product;
  logic                   overflow;

  assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign digit    = 4'(byte_in - CH_ZERO);
  assign lowered  = ((byte_in >= CH_UPPER_A) && (byte_in <= CH_UPPER_Z)) ?
                    8'(byte_in + CASE_OFFSET) : byte_in;
  assign acc_wide = {4'b0000, value_accumulator};
  assign product  = (acc_wide << 3) + (acc_wide << 1) + {{LENGTH_BITS{1'b0}}, digit};
  assign overflow = |product[WIDE_BITS-1:LENGTH_BITS];

  always_comb begin
    phase_next             = phase;
    name_position_next     = name_position;
    name_mismatch_next     = name_mismatch;
    line_has_content_next  = line_has_content;
    value_accumulator_next = value_accumulator;
    value_bad_next         = value_bad;
    digit_seen_next        = digit_seen;
    message_length_next    = message_length;
    bytes_left_next        = bytes_left;
    clear_line             = 1'b0;
    end_headers            = 1'b0;

    result.valid = 1'b0;
    result.data  = byte_in;
    result.first = 1'b0;
    result.last  = 1'b0;

    if (phase == PH_BODY) begin
      result.valid = 1'b1;
      result.first = (bytes_left == message_length);
      result.last  = (bytes_left <= LENGTH_BITS'(1));
      if (bytes_left <= LENGTH_BITS'(1)) begin
        bytes_left_next     = '0;
        message_length_next = '0;
        clear_line          = 1'b1;
      end else begin
        bytes_left_next = bytes_left - LENGTH_BITS'(1);
      end
    end else if (byte_in == CH_LF) begin
      unique case (phase)
        PH_SKIP: begin
          end_headers = 1'b1;
        end
        PH_DIGITS, PH_VTAIL: begin
          if (value_bad || !digit_seen) begin
            end_headers = 1'b1;
          end else begin
            message_length_next = value_accumulator;
            clear_line          = 1'b1;
          end
        end
        PH_IGNORE: begin
          clear_line = 1'b1;
        end
        default: begin
          if (!line_has_content) begin
            end_headers = 1'b1;
          end else begin
            clear_line = 1'b1;
          end
        end
      endcase
    end else begin
      unique case (phase)
        PH_SKIP: begin
          if (!is_blank(byte_in)) begin
            if (is_digit) begin
              digit_seen_next        = 1'b1;
              value_accumulator_next = LENGTH_BITS'(digit);
              phase_next             = PH_DIGITS;
            end else begin
              value_bad_next = 1'b1;
              phase_next     = PH_VTAIL;
            end
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            if (overflow) begin
              value_bad_next = 1'b1;
              phase_next     = PH_VTAIL;
            end else begin
              value_accumulator_next = product[LENGTH_BITS-1:0];
            end
          end else begin
            phase_next = PH_VTAIL;
          end
        end
        PH_IGNORE, PH_VTAIL: begin
        end
        default: begin
          phase_next = PH_NAME;
          if (byte_in != CH_CR) begin
            line_has_content_next = 1'b1;
          end
          if (byte_in == CH_COLON) begin
            if (!name_mismatch && (name_position == 4'(NAME_LEN))) begin
              phase_next = PH_SKIP;
            end else begin
              phase_next = PH_IGNORE;
            end
          end else if ((name_position < 4'(NAME_LEN)) &&
                       (lowered == wanted_char(name_position))) begin
            name_position_next = name_position + 4'd1;
          end else begin
            name_mismatch_next = 1'b1;
          end
        end
      endcase
    end

    if (clear_line || end_headers) begin
      phase_next             = PH_NAME;
      name_position_next     = '0;
      name_mismatch_next     = 1'b0;
      line_has_content_next  = 1'b0;
      value_accumulator_next = '0;
      value_bad_next         = 1'b0;
      digit_seen_next        = 1'b0;
    end
    if (end_headers && (message_length != '0)) begin
      bytes_left_next = message_length;
      phase_next      = PH_BODY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_NAME;
      name_position     <= '0;
      name_mismatch     <= 1'b0;
      line_has_content  <= 1'b0;
      value_accumulator <= '0;
      value_bad         <= 1'b0;
      digit_seen        <= 1'b0;
      message_length    <= '0;
      bytes_left        <= '0;
    end else if (step) begin
      phase             <= phase_next;
      name_position     <= name_position_next;
      name_mismatch     <= name_mismatch_next;
      line_has_content  <= line_has_content_next;
      value_accumulator <= value_accumulator_next;
      value_bad         <= value_bad_next;
      digit_seen        <= digit_seen_next;
      message_length    <= message_length_next;
      bytes_left        <= bytes_left_next;
    end
  end

  a_body_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (bytes_left != '0))
    else $error("Body phase with no bytes left.");

  a_body_count_bounded: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (bytes_left <= message_length))
    else $error("Bytes left exceeds the message length.");

  a_count_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_BODY) |-> (bytes_left == '0))
    else $error("Body counter not cleared outside the body.");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (step && result.valid && result.last) |=> (phase == PH_NAME))
    else $error("Header reading did not restart after the last body byte.");

  a_name_position: assert property (@(posedge clk) disable iff (rst)
    name_position <= 4'(NAME_LEN))
    else $error("Name position ran past the wanted name.");

endmodule

### sv/cld_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Content-length deframer output register
// Holds one body byte and its flags until the downstream transfer.
// ----------------------------------------------------------------------------
module cld_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  cld_pkg::cld_result_t result,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          body_byte,
  output logic                first_of_message,
  output logic                last_of_message
);
  import cld_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      body_byte        <= result.data;
      first_of_message <= result.first;
      last_of_message  <= result.last;
    end
  end

endmodule

### sv/content_length_deframer.sv
`timescale 1ns / 1ps
// Path: a body byte passes through the input register and then the output register before it
// is presented on the output; while the output is stalled it waits in the input register.
// Throughput: one byte per cycle while the output accepts, limited by the parser's one-byte step.
// Header bytes produce no output and are consumed at the same rate, also while the output stalls.
// Reset (synchronous, active high) clears all control state and restarts header reading.
// ----------------------------------------------------------------------------
// Content-length deframer
// Input register, header parser and output register for body extraction.
// ----------------------------------------------------------------------------
module content_length_deframer #(
  parameter int LENGTH_BITS = cld_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] stream_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] body_byte,
  output logic       first_of_message,
  output logic       last_of_message
);
  import cld_pkg::*;

  logic        held_valid;
  logic [7:0]  held_byte;
  logic        step;
  logic        free;
  cld_result_t result;

  assign step     = held_valid && (!result.valid || free);
  assign in_ready = !held_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= stream_byte;
    end
  end

  cld_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .byte_in(held_byte),
    .result (result)
  );

  cld_out_reg u_out_reg (
    .clk             (clk),
    .rst             (rst),
    .load            (step && result.valid),
    .result          (result),
    .free            (free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .body_byte       (body_byte),
    .first_of_message(first_of_message),
    .last_of_message (last_of_message)
  );

endmodule

### tb/content_length_body_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Content-length deframer body checker
// Watches both channels, tracks the header parser state for every input
// transfer, queues the body bytes it should emit and compares each output
// transfer against the oldest queued byte.
// ----------------------------------------------------------------------------
module content_length_body_checker #(
  parameter int LENGTH_BITS = cld_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] stream_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] body_byte,
  input  logic       first_of_message,
  input  logic       last_of_message,
  output int         mismatch_count,
  output int         beats_outstanding
);

  import cld_pkg::*;

  localparam longint unsigned LEN_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LENGTH_BITS);

  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
  } body_beat_t;

  body_beat_t      expected_body[$];
  string           hdr_name = "content-length";

  phase_t          ph;
  int unsigned     name_pos;
  bit              name_mis;
  bit              line_content;
  bit              val_bad;
  bit              digit_seen;
  longint unsigned acc;
  longint unsigned msg_len;
  longint unsigned left;
  int              errors;

  initial begin
    mismatch_count    = 0;
    beats_outstanding = 0;
    errors            = 0;
  end

  function automatic bit blank_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_HT || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  function automatic bit digit_char(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void restart_line();
    ph           = PH_NAME;
    name_pos     = 0;
    name_mis     = 1'b0;
    line_content = 1'b0;
    acc          = 0;
    val_bad      = 1'b0;
    digit_seen   = 1'b0;
  endfunction

  function automatic void close_headers();
    restart_line();
    if (msg_len != 0) begin
      left = msg_len;
      ph   = PH_BODY;
    end
  endfunction

  function automatic void finish_line();
    case (ph)
      PH_SKIP: close_headers();
      PH_DIGITS, PH_VTAIL: begin
        if (val_bad || !digit_seen) begin
          close_headers();
        end else begin
          msg_len = acc;
          restart_line();
        end
      end
      PH_IGNORE: restart_line();
      default: begin
        if (!line_content) close_headers();
        else restart_line();
      end
    endcase
  endfunction

  function automatic void parse_stream_byte(input logic [7:0] c);
    body_beat_t      beat;
    logic [7:0]      low;
    longint unsigned d;
    if (ph == PH_BODY) begin
      beat.data  = c;
      beat.first = (left == msg_len);
      beat.last  = (left <= 1);
      expected_body.push_back(beat);
      if (left <= 1) begin
        left    = 0;
        msg_len = 0;
        restart_line();
      end else begin
        left--;
      end
    end else if (c == CH_LF) begin
      finish_line();
    end else begin
      case (ph)
        PH_SKIP: begin
          if (!blank_char(c)) begin
            if (digit_char(c)) begin
              digit_seen = 1'b1;
              acc        = 64'(c - CH_ZERO);
              ph         = PH_DIGITS;
            end else begin
              val_bad = 1'b1;
              ph      = PH_VTAIL;
            end
          end
        end
        PH_DIGITS: begin
          if (digit_char(c)) begin
            d = 64'(c - CH_ZERO);
            if (acc > (LEN_MAX - d) / 10) begin
              val_bad = 1'b1;
              ph      = PH_VTAIL;
            end else begin
              acc = acc * 10 + d;
            end
          end else begin
            ph = PH_VTAIL;
          end
        end
        PH_IGNORE, PH_VTAIL: ;
        default: begin
          if (c != CH_CR) line_content = 1'b1;
          if (c == CH_COLON) begin
            ph = (!name_mis && name_pos == NAME_LEN) ? PH_SKIP : PH_IGNORE;
          end else begin
            low = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
            if (name_pos < NAME_LEN && low == hdr_name[name_pos]) name_pos++;
            else name_mis = 1'b1;
          end
        end
      endcase
    end
  endfunction

  always @(posedge clk) begin
    body_beat_t want;
    if (rst) begin
      restart_line();
      msg_len = 0;
      left    = 0;
      expected_body.delete();
    end else begin
      if (in_valid && in_ready) parse_stream_byte(stream_byte);
      if (out_valid && out_ready) begin
        if (expected_body.size() == 0) begin
          $error("body transfer 0x%0h arrived with no body byte expected", body_byte);
          errors++;
        end else begin
          want = expected_body.pop_front();
          if (body_byte !== want.data) begin
            $error("body_byte mismatch: expected 0x%0h, actual 0x%0h", want.data, body_byte);
            errors++;
          end
          if (first_of_message !== want.first) begin
            $error("first_of_message mismatch: expected %0b, actual %0b",
                   want.first, first_of_message);
            errors++;
          end
          if (last_of_message !== want.last) begin
            $error("last_of_message mismatch: expected %0b, actual %0b",
                   want.last, last_of_message);
            errors++;
          end
        end
      end
    end
    mismatch_count    <= errors;
    beats_outstanding <= expected_body.size();
  end

endmodule

### tb/tb_content_length_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Content-length deframer testbench
// Feeds directed header sections covering the parser's corner cases, then
// randomised messages mixed with noise and broken headers, with random gaps
// on the input and random back-pressure on the output. A checker alongside
// the block predicts and compares every body byte.
// ----------------------------------------------------------------------------
module tb_content_length_deframer;

  import cld_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int STREAM_ITEMS = 600;
  localparam int HOLD_CYCLES  = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] stream_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] body_byte;
  logic       first_of_message;
  logic       last_of_message;
  int         mismatch_count;
  int         beats_outstanding;

  int unsigned bytes_sent = 0;
  int unsigned sender_calm = 0;
  int unsigned receiver_calm = 0;
  int unsigned cycles = 0;

  content_length_deframer u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .stream_byte      (stream_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .body_byte        (body_byte),
    .first_of_message (first_of_message),
    .last_of_message  (last_of_message)
  );

  content_length_body_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .stream_byte       (stream_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .body_byte         (body_byte),
    .first_of_message  (first_of_message),
    .last_of_message   (last_of_message),
    .mismatch_count    (mismatch_count),
    .beats_outstanding (beats_outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic put_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_len(sender_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic end_line(input bit with_cr);
    if (with_cr) put_byte(CH_CR);
    put_byte(CH_LF);
  endtask

  task automatic put_body(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic put_blank_line();
    case ($urandom_range(0, 2))
      0: put_byte(CH_LF);
      1: end_line(1'b1);
      default: begin
        put_byte(CH_CR);
        end_line(1'b1);
      end
    endcase
  endtask

  function automatic string mixed_case(input string s);
    string t;
    t = s;
    for (int i = 0; i < t.len(); i++) begin
      if (t[i] >= "a" && t[i] <= "z" && $urandom_range(0, 1)) t[i] = t[i] - 8'h20;
    end
    return t;
  endfunction

  function automatic int unsigned body_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 85) return $urandom_range(1, 16);
    return $urandom_range(17, 64);
  endfunction

  task automatic put_length_header(input int unsigned len);
    put_text(mixed_case("content-length"));
    put_byte(CH_COLON);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 4))
        0: put_byte(CH_SPACE);
        1: put_byte(CH_HT);
        2: put_byte(CH_VT);
        3: put_byte(CH_FF);
        default: put_byte(CH_CR);
      endcase
    end
    if ($urandom_range(0, 9) == 0) put_text("00");
    put_text($sformatf("%0d", len));
    if ($urandom_range(0, 7) == 0) put_text(" ;q=1");
    end_line(1'($urandom_range(0, 1)));
  endtask

  task automatic put_other_header();
    case ($urandom_range(0, 4))
      0: put_text("Content-Type: text/plain");
      1: put_text("X-Id: 42");
      2: put_text("content-lengthx: 9");
      3: put_text("Content-Lengt: 8");
      default: put_text("no colon on this line");
    endcase
    end_line(1'($urandom_range(0, 1)));
  endtask

  task automatic put_message();
    int unsigned len;
    len = body_len();
    repeat ($urandom_range(0, 2)) put_other_header();
    if ($urandom_range(0, 5) == 0) put_length_header($urandom_range(1, 99));
    put_length_header(len);
    if ($urandom_range(0, 3) == 0) put_other_header();
    put_blank_line();
    put_body(len);
  endtask

  task automatic put_broken();
    case ($urandom_range(0, 3))
      0: begin
        repeat ($urandom_range(1, 16)) put_byte(8'($urandom_range(0, 255)));
      end
      1: begin
        put_text("Content-Length:");
        case ($urandom_range(0, 4))
          0: put_text("   ");
          1: put_text(" +7");
          2: put_text(" -2");
          3: put_text(" x1");
          default: put_text(" 99999999999");
        endcase
        end_line(1'($urandom_range(0, 1)));
      end
      2: put_length_header($urandom_range(1, 12));
      default: begin
        put_length_header($urandom_range(4, 12));
        put_blank_line();
        put_body($urandom_range(0, 3));
      end
    endcase
  endtask

  task automatic run_directed();
    // A long first body so that the receiver hold-off backs the block up.
    put_text("Content-Length: 30");
    end_line(1'b1);
    end_line(1'b1);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_LF);
    put_byte(CH_CR);
    put_byte(8'h55);
    put_byte(8'hAA);
    put_body(24);
    // Length zero after blanks of every kind: no body, header reading restarts.
    put_text("content-length:");
    put_byte(CH_HT);
    put_byte(CH_VT);
    put_byte(CH_FF);
    put_byte(CH_CR);
    put_text(" 0");
    end_line(1'b1);
    put_byte(CH_LF);
    // Ignored lines, trailing junk after the digits and a line of CRs only.
    put_text("no colon line");
    end_line(1'b1);
    put_text("X-Other: 12");
    end_line(1'b1);
    put_text("CONTENT-LENGTH: 0003;junk");
    end_line(1'b1);
    put_byte(CH_CR);
    end_line(1'b1);
    put_text("abc");
    // The largest value is accepted and then replaced by a later header.
    put_text("Content-Length: 4294967295");
    end_line(1'b1);
    put_text("Content-Length: 2");
    end_line(1'b0);
    end_line(1'b0);
    put_text("xy");
    // Overflow ends the section and keeps the earlier length.
    put_text("Content-Length: 1");
    end_line(1'b1);
    put_text("Content-Length: 4294967296");
    end_line(1'b1);
    put_text("Z");
    // A missing value does the same.
    put_text("Content-Length: 2");
    end_line(1'b1);
    put_text("Content-Length:   ");
    end_line(1'b1);
    put_byte(CH_LF);
    put_byte(CH_CR);
    // Signs are not digits; with no earlier length nothing is emitted.
    put_text("Content-Length: 1");
    end_line(1'b1);
    put_text("Content-Length: +5");
    end_line(1'b1);
    put_text("+");
    put_text("Content-Length: -3");
    end_line(1'b1);
    // Names that must not match: embedded CR, high byte, too long, too short, space before colon.
    put_text("Content-");
    put_byte(CH_CR);
    put_text("Length: 9");
    end_line(1'b1);
    put_byte(8'hE3);
    put_text("ontent-length: 7");
    end_line(1'b1);
    put_text("content-lengthx: 5");
    end_line(1'b1);
    put_text("Content-Lengt: 5");
    end_line(1'b1);
    put_text("content-length : 6");
    end_line(1'b1);
    put_text("Content-Length: 12abc");
    end_line(1'b0);
    end_line(1'b0);
    put_body(12);
  endtask

  initial begin
    int unsigned run;
    int unsigned stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    while (!out_valid) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      run = (receiver_calm != 0) ? receiver_calm : $urandom_range(1, 6);
      receiver_calm = 0;
      repeat (run) @(posedge clk);
      stall = idle_len(receiver_calm);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    while (bytes_sent < STREAM_ITEMS) begin
      if ($urandom_range(0, 99) < 80) put_message();
      else put_broken();
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (beats_outstanding != 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && beats_outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
